// ===== src/smx_pkg.sv =====
`default_nettype none
package smx_pkg;

	localparam int STACK_DEPTH_DEF = 64;
	localparam int REG_COUNT_DEF   = 8;
	localparam int RAM_WORDS_DEF   = 1024;
	localparam int PC_WIDTH_DEF    = 16;

	localparam logic [4:0] OP_SKIP = 5'd0;
	localparam logic [4:0] OP_PUSH = 5'd1;
	localparam logic [4:0] OP_POP  = 5'd2;
	localparam logic [4:0] OP_ADD  = 5'd3;
	localparam logic [4:0] OP_SUB  = 5'd4;
	localparam logic [4:0] OP_MUL  = 5'd5;
	localparam logic [4:0] OP_DIV  = 5'd6;
	localparam logic [4:0] OP_MOD  = 5'd7;
	localparam logic [4:0] OP_IN   = 5'd8;
	localparam logic [4:0] OP_OUT  = 5'd9;
	localparam logic [4:0] OP_DUP  = 5'd10;
	localparam logic [4:0] OP_JMP  = 5'd11;
	localparam logic [4:0] OP_JE   = 5'd12;
	localparam logic [4:0] OP_JNE  = 5'd13;
	localparam logic [4:0] OP_JG   = 5'd14;
	localparam logic [4:0] OP_JGE  = 5'd15;
	localparam logic [4:0] OP_JL   = 5'd16;
	localparam logic [4:0] OP_JLE  = 5'd17;
	localparam logic [4:0] OP_HALT = 5'd18;

	localparam logic [1:0] MD_IMM  = 2'd0;
	localparam logic [1:0] MD_RAM  = 2'd1;
	localparam logic [1:0] MD_REG  = 2'd2;
	localparam logic [1:0] MD_NONE = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_MODE  = 3'd1;
	localparam logic [2:0] ST_HALTED    = 3'd2;
	localparam logic [2:0] ST_UNDERFLOW = 3'd3;
	localparam logic [2:0] ST_OVERFLOW  = 3'd4;
	localparam logic [2:0] ST_DIV_ZERO  = 3'd5;

	typedef struct packed {
		logic [4:0]         operation;
		logic [1:0]         mode;
		logic signed [63:0] immediate_value;
		logic [9:0]         ram_address;
		logic [2:0]         reg_index;
		logic [15:0]        jump_target;
		logic signed [63:0] input_value;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic               out_valid;
		logic signed [63:0] out_value;
		logic               branch_taken;
		logic [15:0]        branch_target;
	} res_item_t;

	typedef struct packed {
		logic       load;
		logic       clr;
		logic       rd_second;
		logic       cap_r;
		logic       cap_l;
		logic       mul_run;
		logic       div_start;
		logic       commit;
		logic [2:0] status;
	} ctl_cmd_t;

	typedef struct packed {
		logic [4:0] op;
		logic [1:0] mode;
		logic       sp_empty;
		logic       sp_lt2;
		logic       sp_full;
		logic       r_zero;
		logic       clr_done;
		logic       mul_done;
		logic       div_busy;
		logic       out_busy;
	} dp_stat_t;

endpackage
`default_nettype wire

// ===== src/smx_div.sv =====
`default_nettype none
module smx_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [63:0] dividend,
	input  wire logic signed [63:0] divisor,
	output logic                    busy,
	output logic signed [63:0]      quo,
	output logic signed [63:0]      rem
);
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [64:0] rem_q;
	logic [63:0] dvd_q;
	logic [63:0] dsr_q;
	logic        negq_q;
	logic        negr_q;
	logic [64:0] trial;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q[63:0], dvd_q[63]} - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'd63) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			dvd_q  <= dividend[63] ? 64'(-dividend) : dividend;
			dsr_q  <= divisor[63] ? 64'(-divisor) : divisor;
			negq_q <= dividend[63] ^ divisor[63];
			negr_q <= dividend[63];
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial;
				dvd_q <= {dvd_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[63:0], dvd_q[63]};
				dvd_q <= {dvd_q[62:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign quo  = negq_q ? 64'(-dvd_q) : dvd_q;
	assign rem  = negr_q ? 64'(-rem_q[63:0]) : rem_q[63:0];

	property p_busy_after_start;
		@(posedge clk) disable iff (!arst_n) start |=> busy_q && cnt_q == 6'd0;
	endproperty
	a_busy_after_start: assert property (p_busy_after_start) else $error("divider not busy");

endmodule
`default_nettype wire

// ===== src/smx_ctl.sv =====
`default_nettype none
module smx_ctl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire smx_pkg::dp_stat_t stat,
	output smx_pkg::ctl_cmd_t      cmd
);
	import smx_pkg::*;

	typedef enum logic [7:0] {
		S_CLR  = 8'b0000_0001,
		S_IDLE = 8'b0000_0010,
		S_DEC  = 8'b0000_0100,
		S_RD1  = 8'b0000_1000,
		S_RD2  = 8'b0001_0000,
		S_MUL  = 8'b0010_0000,
		S_DIV  = 8'b0100_0000,
		S_FIN  = 8'b1000_0000
	} state_t;

	state_t     state_q, state_d;
	logic [2:0] st_q, st_d;
	logic       two_opnd;

	assign two_opnd = (stat.op >= OP_ADD && stat.op <= OP_MOD) ||
	                  (stat.op >= OP_JE && stat.op <= OP_JLE);

	always_comb begin
		state_d = state_q;
		st_d    = st_q;
		cmd     = '0;
		cmd.status = st_q;
		unique case (state_q)
			S_CLR: begin
				cmd.clr = 1'b1;
				if (stat.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DEC;
				end
			end
			S_DEC: begin
				st_d    = ST_OK;
				state_d = S_FIN;
				unique case (stat.op) inside
					OP_PUSH: begin
						if (stat.mode == MD_NONE) st_d = ST_BAD_MODE;
						else if (stat.sp_full) st_d = ST_OVERFLOW;
						else state_d = S_RD1;
					end
					OP_POP: begin
						if (stat.mode != MD_RAM && stat.mode != MD_REG) st_d = ST_BAD_MODE;
						else if (stat.sp_empty) st_d = ST_UNDERFLOW;
						else state_d = S_RD1;
					end
					OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
					OP_JE, OP_JNE, OP_JG, OP_JGE, OP_JL, OP_JLE: begin
						if (stat.sp_lt2) st_d = ST_UNDERFLOW;
						else state_d = S_RD1;
					end
					OP_IN: begin
						if (stat.sp_full) st_d = ST_OVERFLOW;
					end
					OP_OUT: begin
						if (stat.sp_empty) st_d = ST_UNDERFLOW;
						else state_d = S_RD1;
					end
					OP_DUP: begin
						if (stat.sp_empty) st_d = ST_UNDERFLOW;
						else if (stat.sp_full) st_d = ST_OVERFLOW;
						else state_d = S_RD1;
					end
					OP_HALT: st_d = ST_HALTED;
					default: st_d = ST_OK;
				endcase
			end
			S_RD1: begin
				cmd.cap_r     = 1'b1;
				cmd.rd_second = 1'b1;
				state_d = two_opnd ? S_RD2 : S_FIN;
			end
			S_RD2: begin
				cmd.cap_l = 1'b1;
				state_d   = S_FIN;
				if (stat.op == OP_DIV || stat.op == OP_MOD) begin
					if (stat.r_zero) begin
						st_d = ST_DIV_ZERO;
					end else begin
						cmd.div_start = 1'b1;
						state_d       = S_DIV;
					end
				end else if (stat.op == OP_MUL) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul_run = 1'b1;
				if (stat.mul_done) state_d = S_FIN;
			end
			S_DIV: begin
				if (!stat.div_busy) state_d = S_FIN;
			end
			S_FIN: begin
				if (!stat.out_busy) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			st_q    <= ST_OK;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	property p_div_in_div;
		@(posedge clk) disable iff (!arst_n) stat.div_busy |-> state_q == S_DIV;
	endproperty
	a_div_in_div: assert property (p_div_in_div) else $error("divider busy outside div state");

	property p_commit_ok_status;
		@(posedge clk) disable iff (!arst_n)
			cmd.commit && st_q == ST_DIV_ZERO |-> stat.op == OP_DIV || stat.op == OP_MOD;
	endproperty
	a_commit_ok_status: assert property (p_commit_ok_status) else $error("bad div zero status");

endmodule
`default_nettype wire

// ===== src/smx_dp.sv =====
`default_nettype none
module smx_dp #(
	parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF,
	parameter int REG_COUNT   = smx_pkg::REG_COUNT_DEF,
	parameter int RAM_WORDS   = smx_pkg::RAM_WORDS_DEF,
	parameter int PC_WIDTH    = smx_pkg::PC_WIDTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire smx_pkg::in_item_t in_item,
	input  wire logic              res_ready,
	input  wire smx_pkg::ctl_cmd_t cmd,
	output smx_pkg::dp_stat_t      stat,
	output logic                   res_valid,
	output smx_pkg::res_item_t     res_item
);
	import smx_pkg::*;

	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int AW  = $clog2(STACK_DEPTH);
	localparam int RAW = $clog2(RAM_WORDS);
	localparam int RIW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

	in_item_t           item_q;
	logic [SPW-1:0]     sp_q;
	logic [SPW-1:0]     sp_m1, sp_m2;
	logic [63:0]        stack_mem [STACK_DEPTH];
	logic [63:0]        ram_mem [RAM_WORDS];
	logic [63:0]        reg_q [REG_COUNT];
	logic [63:0]        stk_rd_q, ram_rd_q;
	logic signed [63:0] r_q, l_q, pv_q;
	logic [RAW-1:0]     clr_q;
	logic [9:0]         ra_m;
	logic [2:0]         ri_m;
	logic [RAW-1:0]     ram_idx;
	logic [RIW-1:0]     reg_idx;
	logic [1:0]         mcnt_q;
	logic [31:0]        ma, mb;
	logic [63:0]        prod_q, acc_q;
	logic               div_busy;
	logic signed [63:0] quo, rem;
	logic [15:0]        tgt;
	logic               cond;
	logic               ok;
	res_item_t          res_d;
	res_item_t          res_q;
	logic               res_valid_q;
	logic               stk_we;
	logic [AW-1:0]      stk_wa;
	logic [63:0]        stk_wd;
	logic [SPW-1:0]     sp_d;

	// address wrap by compare and subtract of scaled sizes
	always_comb begin
		ra_m = item_q.ram_address;
		for (int k = 6; k >= 0; k--) begin
			if (32'(ra_m) >= (RAM_WORDS << k)) ra_m = ra_m - 10'(RAM_WORDS << k);
		end
		ri_m = item_q.reg_index;
		for (int k = 2; k >= 0; k--) begin
			if (32'(ri_m) >= (REG_COUNT << k)) ri_m = ri_m - 3'(REG_COUNT << k);
		end
	end
	assign ram_idx = RAW'(ra_m);
	assign reg_idx = RIW'(ri_m);

	assign sp_m1 = sp_q - SPW'(1);
	assign sp_m2 = sp_q - SPW'(2);

	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= in_item;
		if (cmd.cap_r) begin
			r_q <= stk_rd_q;
			unique case (item_q.mode)
				MD_IMM:  pv_q <= item_q.immediate_value;
				MD_RAM:  pv_q <= ram_rd_q;
				default: pv_q <= reg_q[reg_idx];
			endcase
		end
		if (cmd.cap_l) l_q <= stk_rd_q;
	end

	// 64x64 low product from three 32x32 partial products
	always_comb begin
		case (mcnt_q)
			2'd0:    begin ma = l_q[31:0];  mb = r_q[31:0];  end
			2'd1:    begin ma = l_q[63:32]; mb = r_q[31:0];  end
			default: begin ma = l_q[31:0];  mb = r_q[63:32]; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mcnt_q <= '0;
		else if (cmd.mul_run) mcnt_q <= mcnt_q + 2'd1;
		else mcnt_q <= '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_run) begin
			prod_q <= 64'(ma) * 64'(mb);
			case (mcnt_q)
				2'd1:    acc_q <= prod_q;
				2'd2,
				2'd3:    acc_q <= acc_q + {prod_q[31:0], 32'd0};
				default: acc_q <= acc_q;
			endcase
		end
	end

	smx_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (stk_rd_q),
		.divisor  (r_q),
		.busy     (div_busy),
		.quo      (quo),
		.rem      (rem)
	);

	always_comb begin
		for (int i = 0; i < 16; i++) tgt[i] = item_q.jump_target[i] & (i < PC_WIDTH);
		case (item_q.operation)
			OP_JE:   cond = (l_q == r_q);
			OP_JNE:  cond = (l_q != r_q);
			OP_JG:   cond = (l_q > r_q);
			OP_JGE:  cond = (l_q >= r_q);
			OP_JL:   cond = (l_q < r_q);
			default: cond = (l_q <= r_q);
		endcase
	end

	assign ok = (cmd.status == ST_OK);

	// effects of one instruction at commit
	always_comb begin
		res_d        = '0;
		res_d.status = cmd.status;
		stk_we       = 1'b0;
		stk_wa       = sp_q[AW-1:0];
		stk_wd       = pv_q;
		sp_d         = sp_q;
		if (ok) begin
			case (item_q.operation) inside
				OP_PUSH: begin
					stk_we = 1'b1;
					sp_d   = sp_q + SPW'(1);
				end
				OP_POP: sp_d = sp_m1;
				OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
					stk_we = 1'b1;
					stk_wa = sp_m2[AW-1:0];
					sp_d   = sp_m1;
					case (item_q.operation)
						OP_ADD:  stk_wd = l_q + r_q;
						OP_SUB:  stk_wd = l_q - r_q;
						OP_MUL:  stk_wd = acc_q;
						OP_DIV:  stk_wd = quo;
						default: stk_wd = rem;
					endcase
				end
				OP_IN: begin
					stk_we = 1'b1;
					stk_wd = item_q.input_value;
					sp_d   = sp_q + SPW'(1);
				end
				OP_OUT: begin
					res_d.out_valid = 1'b1;
					res_d.out_value = r_q;
					sp_d            = sp_m1;
				end
				OP_DUP: begin
					stk_we = 1'b1;
					stk_wd = r_q;
					sp_d   = sp_q + SPW'(1);
				end
				OP_JMP: begin
					res_d.branch_taken  = 1'b1;
					res_d.branch_target = tgt;
				end
				OP_JE, OP_JNE, OP_JG, OP_JGE, OP_JL, OP_JLE: begin
					sp_d = sp_m2;
					if (cond) begin
						res_d.branch_taken  = 1'b1;
						res_d.branch_target = tgt;
					end
				end
				default: sp_d = sp_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		stk_rd_q <= stack_mem[cmd.rd_second ? sp_m2[AW-1:0] : sp_m1[AW-1:0]];
		if (cmd.commit && stk_we) stack_mem[stk_wa] <= stk_wd;
	end

	always_ff @(posedge clk) begin
		ram_rd_q <= ram_mem[ram_idx];
		if (cmd.clr) ram_mem[clr_q] <= '0;
		else if (cmd.commit && ok && item_q.operation == OP_POP && item_q.mode == MD_RAM)
			ram_mem[ram_idx] <= r_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q        <= '0;
			clr_q       <= '0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < REG_COUNT; i++) reg_q[i] <= '0;
		end else begin
			if (cmd.clr) clr_q <= clr_q + RAW'(1);
			if (cmd.commit) begin
				sp_q        <= sp_d;
				res_valid_q <= 1'b1;
				if (ok && item_q.operation == OP_POP && item_q.mode == MD_REG)
					reg_q[reg_idx] <= r_q;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) res_q <= res_d;
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	always_comb begin
		stat          = '0;
		stat.op       = item_q.operation;
		stat.mode     = item_q.mode;
		stat.sp_empty = (sp_q == '0);
		stat.sp_lt2   = (sp_q < SPW'(2));
		stat.sp_full  = (32'(sp_q) >= STACK_DEPTH);
		stat.r_zero   = (r_q == '0);
		stat.clr_done = (32'(clr_q) == RAM_WORDS - 1);
		stat.mul_done = (mcnt_q == 2'd3);
		stat.div_busy = div_busy;
		stat.out_busy = res_valid_q && !res_ready;
	end

	property p_sp_bound;
		@(posedge clk) disable iff (!arst_n) 32'(sp_q) <= STACK_DEPTH;
	endproperty
	a_sp_bound: assert property (p_sp_bound) else $error("stack pointer past depth");

	property p_commit_slot_free;
		@(posedge clk) disable iff (!arst_n) cmd.commit |-> !res_valid_q || res_ready;
	endproperty
	a_commit_slot_free: assert property (p_commit_slot_free) else $error("result overwritten");

endmodule
`default_nettype wire

// ===== src/stack_machine_executor_top.sv =====
`default_nettype none
// channel | signals                        | direction | beat
// in      | in_valid, in_ready, in_item    | input     | one decoded instruction
// res     | res_valid, res_ready, res_item | output    | one result per instruction
//
// beat flow: with no stack read or a decode error the sequencer goes straight to commit; push,
//   pop, out and dup read one operand, two-operand ones two; mul and div/mod (bit-serial) then wait
// the operand stack has one registered read port, so operands come out one per cycle
// after reset the data ram is cleared one word a cycle, with in_ready low until it is done
// a waiting result holds the output register; the next beat is taken and runs
//   up to its commit, which waits for the register to drain
module stack_machine_executor_top #(
	parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF,
	parameter int REG_COUNT   = smx_pkg::REG_COUNT_DEF,
	parameter int RAM_WORDS   = smx_pkg::RAM_WORDS_DEF,
	parameter int PC_WIDTH    = smx_pkg::PC_WIDTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire smx_pkg::in_item_t  in_item,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output smx_pkg::res_item_t      res_item
);
	import smx_pkg::*;

	// command and status between sequencer and datapath
	ctl_cmd_t cmd;
	dp_stat_t stat;

	// sequencer: decode, error checks, operand fetch order, unit waits
	smx_ctl u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: stack, registers, data ram, alu, multiplier, divider, result register
	smx_dp #(
		.STACK_DEPTH (STACK_DEPTH),
		.REG_COUNT   (REG_COUNT),
		.RAM_WORDS   (RAM_WORDS),
		.PC_WIDTH    (PC_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.res_ready (res_ready),
		.cmd       (cmd),
		.stat      (stat),
		.res_valid (res_valid),
		.res_item  (res_item)
	);

endmodule
`default_nettype wire

// ===== verif/stack_machine_executor_top_tb.sv =====
`default_nettype none
module stack_machine_executor_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import smx_pkg::*;

	localparam int SDEPTH = STACK_DEPTH_DEF;
	localparam int NREGS = REG_COUNT_DEF;
	localparam int NWORDS = RAM_WORDS_DEF;
	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_item = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_item_t res_item;

	// predictor state: operand stack, pointer, registers and ram
	logic [63:0] pred_stack [SDEPTH];
	int unsigned pred_sp;
	logic [63:0] pred_regs [NREGS];
	logic [63:0] pred_ram [NWORDS];

	res_item_t pending_results [$];
	int unsigned fail_count = 0;
	int unsigned idle_cycles = 0;
	bit sink_random = 1'b1;
	bit sink_hold = 1'b0;
	bit src_random = 1'b1;

	stack_machine_executor_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.res_valid(res_valid), .res_ready(res_ready), .res_item(res_item)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// signed truncating divide and remainder on raw patterns
	function automatic logic [63:0] sdiv64(input logic [63:0] l, input logic [63:0] r);
		logic [63:0] al, ar, q;
		al = l[63] ? -l : l;
		ar = r[63] ? -r : r;
		q = al / ar;
		return (l[63] != r[63]) ? -q : q;
	endfunction

	function automatic logic [63:0] smod64(input logic [63:0] l, input logic [63:0] r);
		logic [63:0] al, ar, m;
		al = l[63] ? -l : l;
		ar = r[63] ? -r : r;
		m = al % ar;
		return l[63] ? -m : m;
	endfunction

	// executes one instruction against the predictor state
	function automatic res_item_t execute_instr(input in_item_t it);
		res_item_t res;
		logic [63:0] lv, rv;
		logic signed [63:0] ls, rs;
		bit cond;
		bit full;
		res = '0;
		res.status = ST_OK;
		full = pred_sp >= SDEPTH;
		case (it.operation)
			OP_PUSH: begin
				if (it.mode == MD_NONE) res.status = ST_BAD_MODE;
				else if (full) res.status = ST_OVERFLOW;
				else begin
					pred_stack[pred_sp] = (it.mode == MD_IMM) ? it.immediate_value :
						(it.mode == MD_RAM) ? pred_ram[it.ram_address] : pred_regs[it.reg_index];
					pred_sp++;
				end
			end
			OP_POP: begin
				if (it.mode != MD_RAM && it.mode != MD_REG) res.status = ST_BAD_MODE;
				else if (pred_sp < 1) res.status = ST_UNDERFLOW;
				else begin
					if (it.mode == MD_RAM) pred_ram[it.ram_address] = pred_stack[pred_sp-1];
					else pred_regs[it.reg_index] = pred_stack[pred_sp-1];
					pred_sp--;
				end
			end
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
				if (pred_sp < 2) res.status = ST_UNDERFLOW;
				else begin
					rv = pred_stack[pred_sp-1];
					lv = pred_stack[pred_sp-2];
					if ((it.operation == OP_DIV || it.operation == OP_MOD) && rv == 0)
						res.status = ST_DIV_ZERO;
					else begin
						case (it.operation)
							OP_ADD: pred_stack[pred_sp-2] = lv + rv;
							OP_SUB: pred_stack[pred_sp-2] = lv - rv;
							OP_MUL: pred_stack[pred_sp-2] = lv * rv;
							OP_DIV: pred_stack[pred_sp-2] = sdiv64(lv, rv);
							default: pred_stack[pred_sp-2] = smod64(lv, rv);
						endcase
						pred_sp--;
					end
				end
			end
			OP_IN: begin
				if (full) res.status = ST_OVERFLOW;
				else begin
					pred_stack[pred_sp] = it.input_value;
					pred_sp++;
				end
			end
			OP_OUT: begin
				if (pred_sp < 1) res.status = ST_UNDERFLOW;
				else begin
					res.out_valid = 1'b1;
					res.out_value = pred_stack[pred_sp-1];
					pred_sp--;
				end
			end
			OP_DUP: begin
				if (pred_sp < 1) res.status = ST_UNDERFLOW;
				else if (full) res.status = ST_OVERFLOW;
				else begin
					pred_stack[pred_sp] = pred_stack[pred_sp-1];
					pred_sp++;
				end
			end
			OP_JMP: begin
				res.branch_taken = 1'b1;
				res.branch_target = it.jump_target;
			end
			OP_JE, OP_JNE, OP_JG, OP_JGE, OP_JL, OP_JLE: begin
				if (pred_sp < 2) res.status = ST_UNDERFLOW;
				else begin
					rs = pred_stack[pred_sp-1];
					ls = pred_stack[pred_sp-2];
					case (it.operation)
						OP_JE: cond = ls == rs;
						OP_JNE: cond = ls != rs;
						OP_JG: cond = ls > rs;
						OP_JGE: cond = ls >= rs;
						OP_JL: cond = ls < rs;
						default: cond = ls <= rs;
					endcase
					pred_sp -= 2;
					if (cond) begin
						res.branch_taken = 1'b1;
						res.branch_target = it.jump_target;
					end
				end
			end
			OP_HALT: res.status = ST_HALTED;
			default: ;
		endcase
		return res;
	endfunction

	// random idle burst on the sending side, valid dropped for its length
	task automatic src_gap();
		if (src_random && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	// offer one instruction and wait for its beat; valid stays up for the next one
	task automatic send_instr(input in_item_t it);
		src_gap();
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_results.push_back(execute_instr(it));
	endtask

	function automatic logic [63:0] rand64();
		case ($urandom_range(0, 5))
			0: return 64'h8000_0000_0000_0000;
			1: return 64'h7fff_ffff_ffff_ffff;
			2: return '1;
			3: return 64'(signed'($urandom_range(0, 20)) - 10);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic in_item_t make_instr(input logic [4:0] op, input logic [1:0] md,
			input logic [63:0] val);
		in_item_t it;
		it.operation = op;
		it.mode = md;
		it.immediate_value = val;
		it.ram_address = 10'($urandom);
		it.reg_index = 3'($urandom);
		it.jump_target = 16'($urandom);
		it.input_value = rand64();
		return it;
	endfunction

	task automatic push_imm(input logic [63:0] val);
		send_instr(make_instr(OP_PUSH, MD_IMM, val));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	// extremes, error cases and every operation but sub, jg, jge, jl and jle
	task automatic test_directed();
		in_item_t it;
		send_instr(make_instr(OP_OUT, MD_NONE, 0));
		send_instr(make_instr(OP_ADD, MD_IMM, 0));
		send_instr(make_instr(OP_JE, MD_IMM, 0));
		send_instr(make_instr(OP_DUP, MD_IMM, 0));
		send_instr(make_instr(OP_POP, MD_RAM, 0));
		send_instr(make_instr(OP_PUSH, MD_NONE, 0));
		send_instr(make_instr(OP_POP, MD_IMM, 0));
		send_instr(make_instr(OP_POP, MD_NONE, 0));
		it = make_instr(OP_PUSH, MD_RAM, 0);
		it.ram_address = '1;
		send_instr(it);
		push_imm(64'h8000_0000_0000_0000);
		push_imm('1);
		send_instr(make_instr(OP_DIV, MD_IMM, 0));
		push_imm(0);
		send_instr(make_instr(OP_MOD, MD_IMM, 0));
		send_instr(make_instr(OP_IN, MD_IMM, 0));
		it = make_instr(OP_POP, MD_REG, 0);
		it.reg_index = '1;
		send_instr(it);
		send_instr(make_instr(OP_HALT, MD_IMM, 0));
		send_instr(make_instr(OP_SKIP, MD_IMM, 0));
		send_instr(make_instr(5'd31, MD_IMM, 0));
		it = make_instr(OP_JMP, MD_IMM, 0);
		it.jump_target = '1;
		send_instr(it);
		send_instr(make_instr(OP_JNE, MD_IMM, 0));
		send_instr(make_instr(OP_MUL, MD_IMM, 0));
	endtask

	// fill to the top to hit overflow, then drain
	task automatic test_stack_limits();
		repeat (SDEPTH + 2) send_instr(make_instr(OP_DUP, MD_IMM, 0));
		send_instr(make_instr(OP_IN, MD_IMM, 0));
		push_imm(1);
		repeat (SDEPTH + 1) send_instr(make_instr(OP_OUT, MD_IMM, 0));
	endtask

	// mostly well-formed arithmetic and jump sequences with random content
	task automatic test_random(input int unsigned count);
		in_item_t it;
		logic [4:0] op;
		for (int unsigned i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) < 2) begin
				op = 5'($urandom);
				it = make_instr(op, 2'($urandom), rand64());
			end else if (pred_sp < 2 || $urandom_range(0, 3) == 0) begin
				op = ($urandom_range(0, 2) == 0) ? OP_IN : OP_PUSH;
				it = make_instr(op, 2'($urandom_range(0, 2)), rand64());
				it.ram_address = 10'($urandom_range(0, 15));
			end else begin
				op = 5'($urandom_range(OP_POP, OP_JLE));
				it = make_instr(op, 2'($urandom_range(1, 2)), rand64());
				it.ram_address = 10'($urandom_range(0, 15));
			end
			send_instr(it);
		end
	endtask

	// receiver holds off while the sender keeps offering beats
	task automatic test_backpressure();
		sink_hold = 1'b1;
		fork
			begin
				repeat (300) @(posedge clk);
				sink_hold = 1'b0;
			end
			test_random(20);
		join
		wait_drained();
	endtask

	// result sink with random stall bursts
	initial begin
		int unsigned gap;
		gap = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (sink_hold) res_ready <= 1'b0;
			else if (gap != 0) begin
				gap--;
				res_ready <= 1'b0;
			end else if (sink_random && $urandom_range(0, 3) == 0) begin
				gap = $urandom_range(0, 6);
				res_ready <= 1'b0;
			end else res_ready <= 1'b1;
		end
	end

	// checks each result beat against the oldest prediction
	always @(posedge clk) begin
		res_item_t want;
		if (res_valid && res_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result beat %h", $time, res_item);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (res_item.status !== want.status) begin
					$display("%0t: status exp %0d got %0d", $time, want.status, res_item.status);
					fail_count++;
				end
				if (res_item.out_valid !== want.out_valid) begin
					$display("%0t: out_valid exp %b got %b", $time, want.out_valid,
						res_item.out_valid);
					fail_count++;
				end
				if (res_item.out_value !== want.out_value) begin
					$display("%0t: out_value exp %h got %h", $time, want.out_value,
						res_item.out_value);
					fail_count++;
				end
				if (res_item.branch_taken !== want.branch_taken) begin
					$display("%0t: branch_taken exp %b got %b", $time, want.branch_taken,
						res_item.branch_taken);
					fail_count++;
				end
				if (res_item.branch_target !== want.branch_target) begin
					$display("%0t: branch_target exp %h got %h", $time, want.branch_target,
						res_item.branch_target);
					fail_count++;
				end
			end
		end
	end

	// watchdog on cycles without any beat; ram clear after reset is counted in the limit
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (res_valid && res_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		pred_sp = 0;
		foreach (pred_stack[i]) pred_stack[i] = '0;
		foreach (pred_regs[i]) pred_regs[i] = '0;
		foreach (pred_ram[i]) pred_ram[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_stack_limits();
		test_random(180);
		// sender pause until all results are in
		wait_drained();
		test_backpressure();
		test_random(180);
		// last stretch without idling
		src_random = 1'b0;
		sink_random = 1'b0;
		test_random(80);
		wait_drained();
		if (fail_count == 0 && pending_results.size() == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire
